[hw/rtl/qrd_pkg.sv]
// shared types, codes and constants for the query record deframer
package qrd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 24;
    localparam int WORD64_W  = 64;
    localparam int SIZE_W    = 32;
    localparam int FBL_W     = 24;
    localparam int CODE_W    = 4;
    localparam int STATUS_W  = 2;

    localparam logic [FBL_W-1:0] FW_WORD   = FBL_W'(8);
    localparam logic [FBL_W-1:0] FW_SIZE   = FBL_W'(4);
    localparam logic [FBL_W-1:0] FW_CERTSZ = FBL_W'(3);

    localparam logic [CODE_W-1:0] SEC_CODE_LEN       = 4'd0;
    localparam logic [CODE_W-1:0] SEC_CODE_FLOW      = 4'd1;
    localparam logic [CODE_W-1:0] SEC_CODE_PID       = 4'd2;
    localparam logic [CODE_W-1:0] SEC_CODE_PATHSZ    = 4'd3;
    localparam logic [CODE_W-1:0] SEC_CODE_PATH      = 4'd4;
    localparam logic [CODE_W-1:0] SEC_CODE_CHSZ      = 4'd5;
    localparam logic [CODE_W-1:0] SEC_CODE_CH        = 4'd6;
    localparam logic [CODE_W-1:0] SEC_CODE_SHSZ      = 4'd7;
    localparam logic [CODE_W-1:0] SEC_CODE_SH        = 4'd8;
    localparam logic [CODE_W-1:0] SEC_CODE_CERTOBJSZ = 4'd9;
    localparam logic [CODE_W-1:0] SEC_CODE_CERTSZ    = 4'd10;
    localparam logic [CODE_W-1:0] SEC_CODE_CERT      = 4'd11;
    localparam logic [CODE_W-1:0] SEC_CODE_TRAIL     = 4'd12;

    typedef enum logic [12:0] {
        SEC_S_LEN       = 13'b0000000000001,
        SEC_S_FLOW      = 13'b0000000000010,
        SEC_S_PID       = 13'b0000000000100,
        SEC_S_PATHSZ    = 13'b0000000001000,
        SEC_S_PATH      = 13'b0000000010000,
        SEC_S_CHSZ      = 13'b0000000100000,
        SEC_S_CH        = 13'b0000001000000,
        SEC_S_SHSZ      = 13'b0000010000000,
        SEC_S_SH        = 13'b0000100000000,
        SEC_S_CERTOBJSZ = 13'b0001000000000,
        SEC_S_CERTSZ    = 13'b0010000000000,
        SEC_S_CERT      = 13'b0100000000000,
        SEC_S_TRAIL     = 13'b1000000000000
    } sec_state_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING = 2'd0,
        ST_OK      = 2'd1,
        ST_OVERRUN = 2'd2,
        ST_TRUNC   = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  total_length;
        logic              last_byte;
    } qrd_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]   section;
        logic [BYTE_W-1:0]   byte_out;
        logic                record_done;
        logic [STATUS_W-1:0] status;
        logic [WORD64_W-1:0] flow_handle;
        logic [WORD64_W-1:0] process_id;
        logic [LEN_W-1:0]    path_length;
        logic [LEN_W-1:0]    client_hello_length;
        logic [LEN_W-1:0]    server_hello_length;
        logic [LEN_W-1:0]    cert_length;
    } qrd_result_t;

    function automatic logic [CODE_W-1:0] sec_code(input sec_state_t s);
        logic [CODE_W-1:0] c;
        unique case (s)
            SEC_S_LEN:       c = SEC_CODE_LEN;
            SEC_S_FLOW:      c = SEC_CODE_FLOW;
            SEC_S_PID:       c = SEC_CODE_PID;
            SEC_S_PATHSZ:    c = SEC_CODE_PATHSZ;
            SEC_S_PATH:      c = SEC_CODE_PATH;
            SEC_S_CHSZ:      c = SEC_CODE_CHSZ;
            SEC_S_CH:        c = SEC_CODE_CH;
            SEC_S_SHSZ:      c = SEC_CODE_SHSZ;
            SEC_S_SH:        c = SEC_CODE_SH;
            SEC_S_CERTOBJSZ: c = SEC_CODE_CERTOBJSZ;
            SEC_S_CERTSZ:    c = SEC_CODE_CERTSZ;
            SEC_S_CERT:      c = SEC_CODE_CERT;
            default:         c = SEC_CODE_TRAIL;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/qrd_in_stage.sv]
// input register stage holding one accepted word
module qrd_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qrd_pkg::qrd_word_t  in_word,
    input  logic                advance,
    output logic                held_valid,
    output qrd_pkg::qrd_word_t  held_word
);

    logic               valid_reg;
    qrd_pkg::qrd_word_t word_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

[hw/rtl/qrd_parser.sv]
// record walker: section state, field counters, decoded values and checks
module qrd_parser
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  qrd_pkg::qrd_word_t   word,
    output qrd_pkg::qrd_result_t result
);

    localparam int CUR_W = POSITION_BITS + 1;
    localparam int SUM_W = ((CUR_W > qrd_pkg::SIZE_W) ? CUR_W : qrd_pkg::SIZE_W) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0]          pos_reg, pos_next;
    qrd_pkg::sec_state_t               sec_reg, sec_next;
    logic [qrd_pkg::FBL_W-1:0]         fbl_reg, fbl_next;
    logic [qrd_pkg::WORD64_W-1:0]      acc_reg, acc_next;
    logic [qrd_pkg::WORD64_W-1:0]      flow_reg, flow_next;
    logic [qrd_pkg::WORD64_W-1:0]      pid_reg, pid_next;
    logic [qrd_pkg::LEN_W-1:0]         path_reg, path_next;
    logic [qrd_pkg::LEN_W-1:0]         ch_reg, ch_next;
    logic [qrd_pkg::LEN_W-1:0]         sh_reg, sh_next;
    logic [qrd_pkg::LEN_W-1:0]         cert_reg, cert_next;
    qrd_pkg::status_t                  status_reg, status_next;

    logic [CUR_W-1:0]                  cursor;
    logic [SUM_W-1:0]                  cursor_ext, size_ext, tl_ext;
    logic [qrd_pkg::SIZE_W-1:0]        size_word;
    logic [qrd_pkg::WORD64_W-1:0]      acc_shift;
    logic [qrd_pkg::FBL_W-1:0]         fbl_dec;
    logic                              active, field_done, fixed_over, size_over;
    logic                              size_zero, overrun;

    assign cursor     = {1'b0, pos_reg} + CUR_W'(1);
    assign active     = (status_reg == qrd_pkg::ST_PENDING) && (sec_reg != qrd_pkg::SEC_S_TRAIL);
    assign acc_shift  = (sec_reg == qrd_pkg::SEC_S_CERTSZ)
                      ? {40'd0, acc_reg[15:0], word.data_byte}
                      : {word.data_byte, acc_reg[63:8]};
    assign size_word  = (sec_reg == qrd_pkg::SEC_S_CERTSZ)
                      ? {8'd0, acc_shift[23:0]}
                      : acc_shift[63:32];
    assign size_zero  = (size_word == '0);
    assign cursor_ext = SUM_W'(cursor);
    assign size_ext   = SUM_W'(size_word);
    assign tl_ext     = SUM_W'(word.total_length);
    assign fixed_over = cursor_ext > tl_ext;
    assign size_over  = (cursor_ext + size_ext) > tl_ext;
    assign fbl_dec    = (fbl_reg != '0) ? fbl_reg - qrd_pkg::FBL_W'(1) : fbl_reg;
    assign field_done = (fbl_dec == '0);

    always_comb
    begin
        sec_next    = sec_reg;
        fbl_next    = fbl_reg;
        acc_next    = acc_reg;
        flow_next   = flow_reg;
        pid_next    = pid_reg;
        path_next   = path_reg;
        ch_next     = ch_reg;
        sh_next     = sh_reg;
        cert_next   = cert_reg;
        status_next = status_reg;
        overrun     = 1'b0;

        if (active)
        begin
            unique case (sec_reg)
                qrd_pkg::SEC_S_LEN:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (fixed_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            sec_next = qrd_pkg::SEC_S_FLOW;
                            fbl_next = qrd_pkg::FW_WORD;
                        end
                    end
                end
                qrd_pkg::SEC_S_FLOW:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (fixed_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            flow_next = acc_shift;
                            sec_next  = qrd_pkg::SEC_S_PID;
                            fbl_next  = qrd_pkg::FW_WORD;
                        end
                    end
                end
                qrd_pkg::SEC_S_PID:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (fixed_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            pid_next = acc_shift;
                            sec_next = qrd_pkg::SEC_S_PATHSZ;
                            fbl_next = qrd_pkg::FW_SIZE;
                        end
                    end
                end
                qrd_pkg::SEC_S_PATHSZ:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (size_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            path_next = size_word[qrd_pkg::LEN_W-1:0];
                            sec_next  = size_zero ? qrd_pkg::SEC_S_CHSZ : qrd_pkg::SEC_S_PATH;
                            fbl_next  = size_zero ? qrd_pkg::FW_SIZE
                                                  : size_word[qrd_pkg::FBL_W-1:0];
                        end
                    end
                end
                qrd_pkg::SEC_S_CHSZ:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (size_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            ch_next  = size_word[qrd_pkg::LEN_W-1:0];
                            sec_next = size_zero ? qrd_pkg::SEC_S_SHSZ : qrd_pkg::SEC_S_CH;
                            fbl_next = size_zero ? qrd_pkg::FW_SIZE
                                                 : size_word[qrd_pkg::FBL_W-1:0];
                        end
                    end
                end
                qrd_pkg::SEC_S_SHSZ:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (size_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            sh_next  = size_word[qrd_pkg::LEN_W-1:0];
                            sec_next = size_zero ? qrd_pkg::SEC_S_CERTOBJSZ : qrd_pkg::SEC_S_SH;
                            fbl_next = size_zero ? qrd_pkg::FW_SIZE
                                                 : size_word[qrd_pkg::FBL_W-1:0];
                        end
                    end
                end
                qrd_pkg::SEC_S_PATH:
                begin
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        sec_next = qrd_pkg::SEC_S_CHSZ;
                        fbl_next = qrd_pkg::FW_SIZE;
                    end
                end
                qrd_pkg::SEC_S_CH:
                begin
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        sec_next = qrd_pkg::SEC_S_SHSZ;
                        fbl_next = qrd_pkg::FW_SIZE;
                    end
                end
                qrd_pkg::SEC_S_SH:
                begin
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        sec_next = qrd_pkg::SEC_S_CERTOBJSZ;
                        fbl_next = qrd_pkg::FW_SIZE;
                    end
                end
                qrd_pkg::SEC_S_CERTOBJSZ:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (size_over)
                        begin
                            overrun = 1'b1;
                        end
                        else
                        begin
                            sec_next = qrd_pkg::SEC_S_CERTSZ;
                            fbl_next = qrd_pkg::FW_CERTSZ;
                        end
                    end
                end
                qrd_pkg::SEC_S_CERTSZ:
                begin
                    acc_next = acc_shift;
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        if (size_over)
                        begin
                            overrun = 1'b1;
                        end
                        else if (size_zero)
                        begin
                            cert_next   = '0;
                            status_next = qrd_pkg::ST_OK;
                            sec_next    = qrd_pkg::SEC_S_TRAIL;
                            fbl_next    = '0;
                        end
                        else
                        begin
                            cert_next = size_word[qrd_pkg::LEN_W-1:0];
                            sec_next  = qrd_pkg::SEC_S_CERT;
                            fbl_next  = size_word[qrd_pkg::FBL_W-1:0];
                        end
                    end
                end
                qrd_pkg::SEC_S_CERT:
                begin
                    fbl_next = fbl_dec;
                    if (field_done)
                    begin
                        status_next = qrd_pkg::ST_OK;
                        sec_next    = qrd_pkg::SEC_S_TRAIL;
                    end
                end
                default:
                begin
                    sec_next = sec_reg;
                end
            endcase
        end

        if (overrun)
        begin
            status_next = qrd_pkg::ST_OVERRUN;
            sec_next    = qrd_pkg::SEC_S_TRAIL;
            fbl_next    = '0;
        end

        if (word.last_byte && (status_next == qrd_pkg::ST_PENDING))
        begin
            status_next = qrd_pkg::ST_TRUNC;
        end

        pos_next = (pos_reg != POS_MAX) ? pos_reg + POSITION_BITS'(1) : pos_reg;
    end

    always_comb
    begin
        result.section             = active ? qrd_pkg::sec_code(sec_reg)
                                            : qrd_pkg::SEC_CODE_TRAIL;
        result.byte_out            = word.data_byte;
        result.record_done         = word.last_byte;
        result.status              = status_next;
        result.flow_handle         = flow_next;
        result.process_id          = pid_next;
        result.path_length         = path_next;
        result.client_hello_length = ch_next;
        result.server_hello_length = sh_next;
        result.cert_length         = cert_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sec_reg    <= qrd_pkg::SEC_S_LEN;
            fbl_reg    <= qrd_pkg::FW_WORD;
            acc_reg    <= '0;
            flow_reg   <= '0;
            pid_reg    <= '0;
            path_reg   <= '0;
            ch_reg     <= '0;
            sh_reg     <= '0;
            cert_reg   <= '0;
            status_reg <= qrd_pkg::ST_PENDING;
        end
        else if (step_en)
        begin
            if (word.last_byte)
            begin
                // record ends here, back to the start of the layout
                pos_reg    <= '0;
                sec_reg    <= qrd_pkg::SEC_S_LEN;
                fbl_reg    <= qrd_pkg::FW_WORD;
                acc_reg    <= '0;
                flow_reg   <= '0;
                pid_reg    <= '0;
                path_reg   <= '0;
                ch_reg     <= '0;
                sh_reg     <= '0;
                cert_reg   <= '0;
                status_reg <= qrd_pkg::ST_PENDING;
            end
            else
            begin
                pos_reg    <= pos_next;
                sec_reg    <= sec_next;
                fbl_reg    <= fbl_next;
                acc_reg    <= acc_next;
                flow_reg   <= flow_next;
                pid_reg    <= pid_next;
                path_reg   <= path_next;
                ch_reg     <= ch_next;
                sh_reg     <= sh_next;
                cert_reg   <= cert_next;
                status_reg <= status_next;
            end
        end
    end

    a_done_is_trailing: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == qrd_pkg::ST_OK || status_reg == qrd_pkg::ST_OVERRUN)
        |-> (sec_reg == qrd_pkg::SEC_S_TRAIL))
        else $error("finished record not in trailing section");

    a_no_stored_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != qrd_pkg::ST_TRUNC)
        else $error("truncated status survived end of record");

    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == qrd_pkg::ST_PENDING)
        && (sec_reg == qrd_pkg::SEC_S_PATH || sec_reg == qrd_pkg::SEC_S_CH
            || sec_reg == qrd_pkg::SEC_S_SH || sec_reg == qrd_pkg::SEC_S_CERT)
        |-> (fbl_reg != '0))
        else $error("payload section entered with zero bytes left");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && word.last_byte)
        |=> (pos_reg == '0 && sec_reg == qrd_pkg::SEC_S_LEN))
        else $error("record state not cleared after last word");

endmodule

[hw/rtl/qrd_out_stage.sv]
// result register with valid flag toward the output stream
module qrd_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  qrd_pkg::qrd_result_t load_result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qrd_pkg::qrd_result_t out_result
);

    logic                 valid_reg;
    qrd_pkg::qrd_result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

[hw/rtl/query_record_deframer.sv]
// top level of the query record deframer
//
// input stream: one record byte per word, with the record's total length in
// tdata and tlast on the final byte of the record. output stream: one word per
// input word, carrying the byte, its section tag (tuser), the status after the
// byte and every value decoded so far.
// a word is held in the input register, is walked through the record layout
// and lands in the result register, which drives the output. when the
// receiver keeps up, one word per cycle is taken and delivered.
// if the receiver stalls, the result register holds; the input register
// still takes one more word and then s_tready drops until the result moves.
// after a word with tlast the record state returns to its start, so the next
// word begins a new record.
// reset clears both stage valid flags and all record state; no clearing pass
// is needed and s_tready is already high when reset is released.
module query_record_deframer
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // data_byte, total_length
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // byte_out, status, flow_handle, process_id,
                                    // path_length, client_hello_length,
                                    // server_hello_length, cert_length, zero pad
    output logic [3:0]   m_tuser,   // section
    output logic         m_tlast
);

    qrd_pkg::qrd_word_t   in_word, held_word;
    qrd_pkg::qrd_result_t step_result, out_result;
    logic                 held_valid, out_free, step_en;

    always_comb
    begin
        in_word.data_byte    = s_tdata[7:0];
        in_word.total_length = s_tdata[31:8];
        in_word.last_byte    = s_tlast;
    end

    assign step_en = held_valid && out_free;

    qrd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (in_word),
        .advance    (out_free),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    qrd_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .word    (held_word),
        .result  (step_result)
    );

    qrd_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step_en),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tuser = out_result.section;
    assign m_tlast = out_result.record_done;
    assign m_tdata = {6'd0,
                      out_result.cert_length,
                      out_result.server_hello_length,
                      out_result.client_hello_length,
                      out_result.path_length,
                      out_result.process_id,
                      out_result.flow_handle,
                      out_result.status,
                      out_result.byte_out};

endmodule

[bench/query_record_deframer_tb.sv]
// self-checking bench for the query record deframer: record builder, byte driver, result checker
module query_record_deframer_tb;

    typedef enum int {
        REC_GOOD,
        REC_CUT,
        REC_SHORT_LEN,
        REC_HUGE,
        REC_NOISE
    } rec_shape_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    qrd_pkg::qrd_word_t   byte_q[$];
    qrd_pkg::qrd_result_t expect_q[$];

    logic        in_taken = 1'b0;
    logic        stall_rx = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          sent_count = 0;
    int          out_count = 0;
    int          fail_count = 0;

    // predicted record state
    logic [23:0]      rec_pos;
    logic [3:0]       cur_sect;
    logic [31:0]      left_in_field;
    logic [63:0]      shift_word;
    logic [63:0]      flow_seen;
    logic [63:0]      pid_seen;
    logic [23:0]      size_seen[4];
    qrd_pkg::status_t rec_status;

    query_record_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] field_width(input logic [3:0] s);
        case (s)
            qrd_pkg::SEC_CODE_LEN, qrd_pkg::SEC_CODE_FLOW, qrd_pkg::SEC_CODE_PID:
                return 32'(qrd_pkg::FW_WORD);
            qrd_pkg::SEC_CODE_PATHSZ, qrd_pkg::SEC_CODE_CHSZ, qrd_pkg::SEC_CODE_SHSZ,
            qrd_pkg::SEC_CODE_CERTOBJSZ:
                return 32'(qrd_pkg::FW_SIZE);
            qrd_pkg::SEC_CODE_CERTSZ:
                return 32'(qrd_pkg::FW_CERTSZ);
            default:
                return 32'd0;
        endcase
    endfunction

    task automatic start_field(input logic [3:0] s);
        cur_sect      = s;
        left_in_field = field_width(s);
        shift_word    = '0;
    endtask

    task automatic clear_record();
        rec_pos    = '0;
        flow_seen  = '0;
        pid_seen   = '0;
        foreach (size_seen[i])
            size_seen[i] = '0;
        rec_status = qrd_pkg::ST_PENDING;
        start_field(qrd_pkg::SEC_CODE_LEN);
    endtask

    task automatic mark_overrun();
        rec_status    = qrd_pkg::ST_OVERRUN;
        cur_sect      = qrd_pkg::SEC_CODE_TRAIL;
        left_in_field = '0;
    endtask

    // closes a length, handle, id or size field once its last byte is in
    task automatic close_field(input logic [63:0] cursor, input logic [23:0] tl);
        logic [63:0] v;
        logic [3:0]  idx;
        if (cur_sect <= qrd_pkg::SEC_CODE_PID)
        begin
            if (cursor > 64'(tl))
                mark_overrun();
            else
            begin
                if (cur_sect == qrd_pkg::SEC_CODE_FLOW)
                    flow_seen = shift_word;
                if (cur_sect == qrd_pkg::SEC_CODE_PID)
                    pid_seen = shift_word;
                start_field(cur_sect + 4'd1);
            end
        end
        else
        begin
            if (cur_sect == qrd_pkg::SEC_CODE_CERTSZ)
                v = {40'd0, shift_word[23:0]};
            else
                v = {32'd0, shift_word[63:32]};
            if (cursor + v > 64'(tl))
                mark_overrun();
            else if (cur_sect == qrd_pkg::SEC_CODE_CERTOBJSZ)
                start_field(qrd_pkg::SEC_CODE_CERTSZ);
            else if (cur_sect == qrd_pkg::SEC_CODE_CERTSZ)
            begin
                size_seen[3] = v[23:0];
                if (v == 0)
                begin
                    rec_status    = qrd_pkg::ST_OK;
                    cur_sect      = qrd_pkg::SEC_CODE_TRAIL;
                    left_in_field = '0;
                end
                else
                begin
                    cur_sect      = qrd_pkg::SEC_CODE_CERT;
                    left_in_field = v[31:0];
                end
            end
            else
            begin
                idx = (cur_sect - qrd_pkg::SEC_CODE_PATHSZ) >> 1;
                size_seen[idx[1:0]] = v[23:0];
                if (v == 0)
                    start_field(cur_sect + 4'd2);
                else
                begin
                    cur_sect      = cur_sect + 4'd1;
                    left_in_field = v[31:0];
                end
            end
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic [23:0] tl, input logic last,
                                output qrd_pkg::qrd_result_t res);
        logic [63:0] cursor;
        logic [3:0]  tag;
        cursor = 64'(rec_pos) + 64'd1;
        tag = (rec_status == qrd_pkg::ST_PENDING && cur_sect < qrd_pkg::SEC_CODE_TRAIL)
            ? cur_sect : qrd_pkg::SEC_CODE_TRAIL;
        if (tag != qrd_pkg::SEC_CODE_TRAIL)
        begin
            if (cur_sect == qrd_pkg::SEC_CODE_PATH || cur_sect == qrd_pkg::SEC_CODE_CH ||
                cur_sect == qrd_pkg::SEC_CODE_SH || cur_sect == qrd_pkg::SEC_CODE_CERT)
            begin
                if (left_in_field > 0)
                    left_in_field--;
                if (left_in_field == 0)
                begin
                    if (cur_sect == qrd_pkg::SEC_CODE_CERT)
                    begin
                        rec_status = qrd_pkg::ST_OK;
                        cur_sect   = qrd_pkg::SEC_CODE_TRAIL;
                    end
                    else
                        start_field(cur_sect + 4'd1);
                end
            end
            else
            begin
                // cert size is big-endian, the other words little-endian
                if (cur_sect == qrd_pkg::SEC_CODE_CERTSZ)
                    shift_word = {40'd0, shift_word[15:0], b};
                else
                    shift_word = {b, shift_word[63:8]};
                if (left_in_field > 0)
                    left_in_field--;
                if (left_in_field == 0)
                    close_field(cursor, tl);
            end
        end
        if (rec_pos != '1)
            rec_pos++;
        if (last && rec_status == qrd_pkg::ST_PENDING)
            rec_status = qrd_pkg::ST_TRUNC;
        res.section             = tag;
        res.byte_out            = b;
        res.record_done         = last;
        res.status              = rec_status;
        res.flow_handle         = flow_seen;
        res.process_id          = pid_seen;
        res.path_length         = size_seen[0];
        res.client_hello_length = size_seen[1];
        res.server_hello_length = size_seen[2];
        res.cert_length         = size_seen[3];
        if (last)
            clear_record();
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_word(input logic [7:0] b, input logic [23:0] tl, input logic last);
        qrd_pkg::qrd_word_t w;
        w.data_byte    = b;
        w.total_length = tl;
        w.last_byte    = last;
        byte_q.push_back(w);
    endtask

    task automatic add_record(input rec_shape_t shape, input int max_pay);
        logic [7:0]  body[$];
        logic [31:0] sz[4];
        logic [31:0] obj_size;
        int          huge_at;
        int          trail;
        int          n;
        int          cert_bytes;
        logic [23:0] tl;
        bit          jitter;
        huge_at = (shape == REC_HUGE) ? $urandom_range(0, 4) : -1;
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < 4; i++)
            sz[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, max_pay);
        if (shape == REC_NOISE)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                body.push_back(8'($urandom));
        end
        else
        begin
            repeat (24)
                body.push_back(8'($urandom));
            for (int i = 0; i < 3; i++)
            begin
                if (huge_at == i)
                    sz[i] = $urandom | 32'h0100_0000;
                for (int k = 0; k < 4; k++)
                    body.push_back(sz[i][8*k +: 8]);
                n = (sz[i] > 255) ? 3 : sz[i];
                repeat (n)
                    body.push_back(8'($urandom));
            end
            if (huge_at == 4)
                sz[3] = ($urandom_range(0, 1) == 0) ? 32'h00FF_FFFF : 32'($urandom_range(256, 24'hFFFFFF));
            cert_bytes = (sz[3] > 255) ? 3 : sz[3];
            // object size one past the end of the record, or anything that fits
            if (huge_at == 3)
                obj_size = 3 + cert_bytes + trail + 1;
            else
                obj_size = $urandom_range(0, 3 + cert_bytes + trail);
            for (int k = 0; k < 4; k++)
                body.push_back(obj_size[8*k +: 8]);
            for (int k = 2; k >= 0; k--)
                body.push_back(sz[3][8*k +: 8]);
            repeat (cert_bytes + trail)
                body.push_back(8'($urandom));
        end
        tl = 24'(body.size());
        case (shape)
            REC_GOOD:
                if ($urandom_range(0, 3) == 0)
                    tl = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF
                                                     : 24'($urandom_range(body.size(), 24'hFFFFFF));
            REC_CUT:
            begin
                n = $urandom_range(1, body.size() - 1);
                while (body.size() > n)
                    void'(body.pop_back());
            end
            REC_SHORT_LEN:
                tl = 24'($urandom_range(0, body.size() - 1));
            REC_NOISE:
                tl = 24'($urandom);
            default:
                ;
        endcase
        jitter = ($urandom_range(0, 7) == 0);
        foreach (body[i])
            push_word(body[i], (jitter && $urandom_range(0, 3) == 0) ? 24'($urandom) : tl,
                      i == body.size() - 1);
    endtask

    // input side
    always @(negedge clk)
    begin : byte_driver
        qrd_pkg::qrd_word_t w;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (byte_q.size() > 0)
            begin
                w = byte_q.pop_front();
                s_tdata  <= {w.total_length, w.data_byte};
                s_tlast  <= w.last_byte;
                s_tvalid <= 1'b1;
                tx_gap   <= gap_len((sent_count % 200) < 40);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_rx)
                m_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap   <= rx_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap   <= gap_len((out_count % 200) >= 100 && (out_count % 200) < 150);
            end
        end
    end

    initial
    begin
        while (out_count < 150)
            @(posedge clk);
        @(negedge clk);
        stall_rx <= 1'b1;
        repeat (80)
            @(negedge clk);
        stall_rx <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        qrd_pkg::qrd_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_count++;
                if (expect_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    check_field("section", 64'(want.section), 64'(m_tuser));
                    check_field("byte_out", 64'(want.byte_out), 64'(m_tdata[7:0]));
                    check_field("record_done", 64'(want.record_done), 64'(m_tlast));
                    check_field("status", 64'(want.status), 64'(m_tdata[9:8]));
                    check_field("flow_handle", want.flow_handle, m_tdata[73:10]);
                    check_field("process_id", want.process_id, m_tdata[137:74]);
                    check_field("path_length", 64'(want.path_length),
                                64'(m_tdata[161:138]));
                    check_field("client_hello_length", 64'(want.client_hello_length),
                                64'(m_tdata[185:162]));
                    check_field("server_hello_length", 64'(want.server_hello_length),
                                64'(m_tdata[209:186]));
                    check_field("cert_length", 64'(want.cert_length),
                                64'(m_tdata[233:210]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                sent_count++;
                deframe_byte(s_tdata[7:0], s_tdata[31:8], s_tlast, want);
                expect_q.push_back(want);
            end
            in_taken <= s_tvalid && s_tready;
        end
    end

    initial
    begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        clear_record();

        // lone last byte, record truncated inside the length field
        push_word(8'hA5, 24'd0, 1'b1);
        // zero total length: length field overruns, the next byte is trailing
        repeat (8)
            push_word(8'hFF, 24'd0, 1'b0);
        push_word(8'h00, 24'd0, 1'b1);
        // minimal record, every size zero, cert size zero ends it at once
        repeat (8)
            push_word(8'h00, 24'd43, 1'b0);
        repeat (8)
            push_word(8'hFF, 24'd43, 1'b0);
        repeat (8)
            push_word(8'h80, 24'd43, 1'b0);
        repeat (18)
            push_word(8'h00, 24'd43, 1'b0);
        push_word(8'h00, 24'd43, 1'b1);

        while (byte_q.size() < 600)
        begin
            r = $urandom_range(0, 99);
            add_record(r < 50 ? REC_GOOD : r < 65 ? REC_CUT : r < 78 ? REC_SHORT_LEN :
                       r < 90 ? REC_HUGE : REC_NOISE,
                       ($urandom_range(0, 19) == 0) ? 120 : 6);
        end

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
